// ===== hw/rtl/spi_slave_packet_framer_macros.svh =====
// assertion macros for the spi slave packet framer
`ifndef SPI_SLAVE_PACKET_FRAMER_MACROS_SVH
`define SPI_SLAVE_PACKET_FRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spf check failed");

// next-cycle implication, checked out of reset
`define SPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spf check failed");

`endif

// ===== hw/rtl/spf_pkg.sv =====
// shared constants, types and helpers for the spi slave packet framer
package spf_pkg;

  localparam int IN_DEPTH  = 64;
  localparam int OUT_DEPTH = 64;
  localparam int IN_AW     = $clog2(IN_DEPTH);
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int IN_CW     = $clog2(IN_DEPTH + 1);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_BUS     = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_READ    = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PH_RECEIVING = 3'b001,
    PH_BUSY      = 3'b010,
    PH_SENDING   = 3'b100
  } phase_t;

  localparam logic [1:0] MODE_RECEIVING = 2'd0;
  localparam logic [1:0] MODE_BUSY      = 2'd1;
  localparam logic [1:0] MODE_SENDING   = 2'd2;

  typedef struct packed {
    logic capture;
    logic step;
    logic rx_store;
    logic tx_fetch;
    logic host_write;
    logic host_read;
    logic clear_counts;
    logic load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic rx_done;
    logic tx_done;
  } status_t;

  function automatic logic [1:0] phase_to_mode(input phase_t ph);
    logic [1:0] m;
    unique case (ph)
      PH_RECEIVING: m = MODE_RECEIVING;
      PH_BUSY:      m = MODE_BUSY;
      PH_SENDING:   m = MODE_SENDING;
      default:      m = MODE_RECEIVING;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/spf_ctrl.sv =====
// sequencer and framing mode controller for the spi slave packet framer
module spf_ctrl
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  status_t    status,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done,
  output logic [1:0] mode
);

  typedef enum logic [2:0] {
    SEQ_IDLE   = 3'b001,
    SEQ_ACCESS = 3'b010,
    SEQ_REPLY  = 3'b100
  } seq_t;

  seq_t   seq;
  seq_t   seq_next;
  phase_t phase;
  phase_t phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq   <= SEQ_IDLE;
      phase <= PH_RECEIVING;
    end else begin
      seq   <= seq_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    seq_next   = seq;
    phase_next = phase;
    cmd        = '0;
    unique case (seq)
      SEQ_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          seq_next    = SEQ_ACCESS;
        end
      end
      SEQ_ACCESS: begin
        cmd.step = 1'b1;
        seq_next = SEQ_REPLY;
        unique case (status.req)
          REQ_BUS: begin
            unique case (phase)
              PH_BUSY: begin
                cmd.load = 1'b1;
              end
              PH_RECEIVING: begin
                cmd.rx_store = 1'b1;
                if (status.rx_done) begin
                  cmd.load   = 1'b1;
                  phase_next = PH_BUSY;
                end
              end
              PH_SENDING: begin
                cmd.tx_fetch = 1'b1;
                cmd.load     = 1'b1;
                if (status.tx_done) begin
                  phase_next = PH_RECEIVING;
                end
              end
              default: phase_next = PH_RECEIVING;
            endcase
          end
          REQ_WRITE: cmd.host_write = 1'b1;
          REQ_READ:  cmd.host_read  = 1'b1;
          REQ_RELEASE: begin
            if (phase == PH_BUSY) begin
              cmd.clear_counts = 1'b1;
              phase_next       = PH_SENDING;
            end
          end
          default: ;
        endcase
      end
      SEQ_REPLY: begin
        seq_next = SEQ_IDLE;
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  assign busy = (seq != SEQ_IDLE);
  assign done = (seq == SEQ_REPLY);
  assign mode = phase_to_mode(phase);

endmodule

// ===== hw/rtl/spf_dp.sv =====
// buffers, counters and result registers for the spi slave packet framer
module spf_dp
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [1:0] req_type,
  input  logic [7:0] rx_byte,
  input  logic [5:0] buf_index,
  input  logic [7:0] write_value,
  output status_t    status,
  output logic       tx_load,
  output logic [7:0] tx_byte,
  output logic [7:0] read_data
);

  // captured request
  req_t       req_q;
  logic [7:0] rx_byte_q;
  logic [5:0] buf_index_q;
  logic [7:0] write_value_q;

  logic [7:0] rx_mem [IN_DEPTH];
  logic [7:0] tx_mem [OUT_DEPTH];
  logic [7:0] rx_rdata;
  logic [7:0] tx_rdata;

  logic [IN_CW-1:0]  rx_count;
  logic [OUT_CW-1:0] tx_count;
  logic [7:0]        rx_len;
  logic [7:0]        tx_len;

  logic load_q;
  logic fetch_q;
  logic rd_q;

  logic [IN_CW-1:0]  rx_inc;
  logic [OUT_CW-1:0] tx_inc;
  logic [7:0]        rx_len_eff;
  logic              rx_room;
  logic              tx_room;
  logic              rx_we;
  logic              tx_rd_en;
  logic              rd_ok;
  logic              wr_ok;
  logic              tx_we;
  logic [IN_AW-1:0]  rd_addr;
  logic [OUT_AW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q         <= req_t'(req_type);
      rx_byte_q     <= rx_byte;
      buf_index_q   <= buf_index;
      write_value_q <= write_value;
    end
  end

  assign rx_room    = (32'(rx_count) < IN_DEPTH);
  assign tx_room    = (32'(tx_count) < OUT_DEPTH);
  assign rx_inc     = rx_room ? rx_count + IN_CW'(1) : rx_count;
  assign tx_inc     = tx_room ? tx_count + OUT_CW'(1) : tx_count;
  // byte 0 of the packet is its length, seen as it arrives
  assign rx_len_eff = (rx_count == '0) ? rx_byte_q : rx_len;

  assign status.req     = req_q;
  assign status.rx_done = (32'(rx_inc) >= 32'(rx_len_eff)) || (32'(rx_inc) >= IN_DEPTH);
  assign status.tx_done = (32'(tx_inc) > 32'(tx_len)) || (32'(tx_inc) >= OUT_DEPTH);

  assign rx_we    = cmd.rx_store && rx_room;
  assign tx_rd_en = cmd.tx_fetch && tx_room;
  assign rd_ok    = (32'(buf_index_q) < IN_DEPTH);
  assign wr_ok    = (32'(buf_index_q) < OUT_DEPTH);
  assign tx_we    = cmd.host_write && wr_ok;
  assign rd_addr  = IN_AW'(buf_index_q);
  assign wr_addr  = OUT_AW'(buf_index_q);

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_count[IN_AW-1:0]] <= rx_byte_q;
    end
    if (cmd.host_read) begin
      rx_rdata <= rx_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[wr_addr] <= write_value_q;
    end
    if (tx_rd_en) begin
      tx_rdata <= tx_mem[tx_count[OUT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we && (rx_count == '0)) begin
      rx_len <= rx_byte_q;
    end
    if (tx_we && (wr_addr == '0)) begin
      tx_len <= write_value_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= '0;
      tx_count <= '0;
    end else if (cmd.clear_counts) begin
      rx_count <= '0;
      tx_count <= '0;
    end else begin
      if (rx_we) begin
        rx_count <= rx_inc;
      end
      if (tx_rd_en) begin
        tx_count <= tx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      load_q  <= cmd.load;
      fetch_q <= tx_rd_en;
      rd_q    <= cmd.host_read && rd_ok;
    end
  end

  assign tx_load   = load_q;
  assign tx_byte   = fetch_q ? tx_rdata : 8'h00;
  assign read_data = rd_q ? rx_rdata : 8'h00;

endmodule

// ===== hw/rtl/spi_slave_packet_framer.sv =====
// spi slave packet framer: a new item is taken only while busy is low
// the item is captured, then the buffer memory access runs with registered read data,
// then the result is shown for one cycle on done
// rst (synchronous, active high) returns the mode to receiving and clears both counts
// buffer contents are not cleared by reset and hold until written
// done is not held off: the result stays on the outputs until the next item's access
`include "spi_slave_packet_framer_macros.svh"

module spi_slave_packet_framer
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [7:0] rx_byte,
  input  logic [5:0] buf_index,
  input  logic [7:0] write_value,
  output logic       done,
  output logic       tx_load,
  output logic [7:0] tx_byte,
  output logic [7:0] read_data,
  output logic [1:0] mode
);

  cmd_t    cmd;
  status_t status;

  spf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .mode   (mode)
  );

  spf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .rx_byte     (rx_byte),
    .buf_index   (buf_index),
    .write_value (write_value),
    .status      (status),
    .tx_load     (tx_load),
    .tx_byte     (tx_byte),
    .read_data   (read_data)
  );

  `SPF_ASSERT_NOW(a_done_in_busy, done, busy)
  `SPF_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
  `SPF_ASSERT_NEXT(a_done_frees, done, !busy)
  `SPF_ASSERT_NOW(a_no_load_zero, done && !tx_load, tx_byte == 8'h00)

endmodule
